[rtl/pol_pkg.sv]
// Shared types, codes and sizes for the positional ordered list.
package pol_pkg;

	localparam int POL_CAPACITY = 64;
	localparam int POL_DATA_W   = 32;

	localparam logic [2:0] CMD_READ      = 3'd0;
	localparam logic [2:0] CMD_FIND      = 3'd1;
	localparam logic [2:0] CMD_INSERT    = 3'd2;
	localparam logic [2:0] CMD_REMOVE    = 3'd3;
	localparam logic [2:0] CMD_OVERWRITE = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	localparam logic [7:0] POS_ABSENT = 8'hFF;

	typedef struct packed {
		logic [2:0]                   command;
		logic [6:0]                   position;
		logic signed [POL_DATA_W-1:0] value;
	} pol_req_t;

	typedef struct packed {
		logic [1:0]                   status;
		logic signed [POL_DATA_W-1:0] read_value;
		logic signed [7:0]            found_position;
		logic [6:0]                   list_size;
		logic                         is_empty;
	} pol_res_t;

endpackage

[rtl/pol_ram.sv]
// Entry store: one write port and one registered read port.
module pol_ram #(
	parameter int DEPTH = pol_pkg::POL_CAPACITY,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [AW-1:0]                  waddr,
	input  logic [pol_pkg::POL_DATA_W-1:0] wdata,
	input  logic                           re,
	input  logic [AW-1:0]                  raddr,
	output logic [pol_pkg::POL_DATA_W-1:0] rdata
);
	import pol_pkg::*;

	logic [POL_DATA_W-1:0] mem_q [DEPTH];
	logic [POL_DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/positional_ordered_list.sv]
// Positional ordered list: a bounded list of signed words addressed by 1-based position.
// Bad command, bad position, full, overwrite and append finish from idle; read fetches one
// entry; find scans from the front to a match or the end; insert shifts later entries back
// and writes the value; remove shifts later entries forward. Throughput is one command at
// a time; every moved or searched entry uses the single read and single write port.
// Reset clears the size and the sequencer; the store is not cleared. Results cannot stall.
module positional_ordered_list #(
	parameter int CAPACITY = pol_pkg::POL_CAPACITY
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pol_pkg::pol_req_t request,
	output logic              done,
	output pol_pkg::pol_res_t result
);
	import pol_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int WW = ((CW > 7) ? CW : 7) + 1;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_READ = 6'b000010,
		S_FIND = 6'b000100,
		S_INS  = 6'b001000,
		S_PUT  = 6'b010000,
		S_REM  = 6'b100000
	} state_t;

	state_t   state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] pos_m1_q, pos_m1_d;
	logic [POL_DATA_W-1:0] val_q, val_d;
	logic     done_q, done_d;
	pol_res_t res_q, res_d;

	logic                  we, re;
	logic [AW-1:0]         waddr, raddr;
	logic [POL_DATA_W-1:0] wdata, rdata;

	logic          accept;
	logic [WW-1:0] pos_w, cnt_w, pos_m1_w;
	logic          pos_nz, in_list, ins_ok, full;
	logic [CW:0]   idx_p2;

	pol_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign pos_w    = WW'(request.position);
	assign cnt_w    = WW'(count_q);
	assign pos_m1_w = pos_w - WW'(1);
	assign pos_nz   = (request.position != 7'd0);
	assign in_list  = pos_nz && (pos_w <= cnt_w);
	assign ins_ok   = pos_nz && (pos_w <= cnt_w + WW'(1));
	assign full     = (cnt_w == WW'(CAPACITY));
	assign idx_p2   = {1'b0, idx_q} + (CW+1)'(2);

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		idx_d    = idx_q;
		pos_m1_d = pos_m1_q;
		val_d    = val_q;
		done_d   = 1'b0;
		res_d    = res_q;
		we       = 1'b0;
		waddr    = '0;
		wdata    = val_q;
		re       = 1'b0;
		raddr    = '0;

		// Default result fields; each finishing arm fills in what it owns.
		res_d.status         = ST_OK;
		res_d.read_value     = '0;
		res_d.found_position = '0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					pos_m1_d = CW'(pos_m1_w);
					val_d    = request.value;
					unique case (request.command)
						CMD_READ: begin
							if (in_list) begin
								re      = 1'b1;
								raddr   = AW'(pos_m1_w);
								state_d = S_READ;
							end else begin
								res_d.status = ST_INVALID;
								done_d       = 1'b1;
							end
						end
						CMD_FIND: begin
							if (count_q == '0) begin
								res_d.found_position = POS_ABSENT;
								done_d               = 1'b1;
							end else begin
								re      = 1'b1;
								raddr   = '0;
								idx_d   = '0;
								state_d = S_FIND;
							end
						end
						CMD_INSERT: begin
							if (!ins_ok) begin
								res_d.status = ST_INVALID;
								done_d       = 1'b1;
							end else if (full) begin
								res_d.status = ST_FULL;
								done_d       = 1'b1;
							end else if (pos_m1_w == cnt_w) begin
								// append: no entry moves
								we      = 1'b1;
								waddr   = AW'(pos_m1_w);
								wdata   = request.value;
								count_d = count_q + CW'(1);
								done_d  = 1'b1;
							end else begin
								re      = 1'b1;
								raddr   = AW'(count_q - CW'(1));
								idx_d   = count_q;
								state_d = S_INS;
							end
						end
						CMD_REMOVE: begin
							if (!in_list) begin
								res_d.status = ST_INVALID;
								done_d       = 1'b1;
							end else if (pos_w == cnt_w) begin
								// last entry: drop without moving anything
								count_d = count_q - CW'(1);
								done_d  = 1'b1;
							end else begin
								re      = 1'b1;
								raddr   = AW'(pos_w);
								idx_d   = CW'(pos_m1_w);
								state_d = S_REM;
							end
						end
						CMD_OVERWRITE: begin
							if (in_list) begin
								we    = 1'b1;
								waddr = AW'(pos_m1_w);
								wdata = request.value;
							end else begin
								res_d.status = ST_INVALID;
							end
							done_d = 1'b1;
						end
						default: begin
							res_d.status = ST_INVALID;
							done_d       = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				res_d.read_value = rdata;
				done_d           = 1'b1;
				state_d          = S_IDLE;
			end
			S_FIND: begin
				priority if (rdata == val_q) begin
					res_d.found_position = 8'(idx_q + CW'(1));
					done_d               = 1'b1;
					state_d              = S_IDLE;
				end else if (idx_q + CW'(1) == count_q) begin
					res_d.found_position = POS_ABSENT;
					done_d               = 1'b1;
					state_d              = S_IDLE;
				end else begin
					re    = 1'b1;
					raddr = AW'(idx_q + CW'(1));
					idx_d = idx_q + CW'(1);
				end
			end
			S_INS: begin
				// move entry idx-1 back to idx
				we    = 1'b1;
				waddr = idx_q[AW-1:0];
				wdata = rdata;
				idx_d = idx_q - CW'(1);
				if (idx_q - CW'(1) == pos_m1_q) begin
					state_d = S_PUT;
				end else begin
					re    = 1'b1;
					raddr = AW'(idx_q - CW'(2));
				end
			end
			S_PUT: begin
				we      = 1'b1;
				waddr   = pos_m1_q[AW-1:0];
				wdata   = val_q;
				count_d = count_q + CW'(1);
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			S_REM: begin
				// move entry idx+1 forward to idx
				we    = 1'b1;
				waddr = idx_q[AW-1:0];
				wdata = rdata;
				if (idx_p2 < {1'b0, count_q}) begin
					re    = 1'b1;
					raddr = AW'(idx_p2);
					idx_d = idx_q + CW'(1);
				end else begin
					count_d = count_q - CW'(1);
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		res_d.list_size = 7'(count_d);
		res_d.is_empty  = (count_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		pos_m1_q <= pos_m1_d;
		val_q    <= val_d;
		if (done_d) begin
			res_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = res_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result transfer while sequencer busy");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, count_q} <= (CW+1)'(CAPACITY))
		else $error("entry count above capacity");

	a_find_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIND) |-> (idx_q < count_q))
		else $error("search index past end of list");

	a_full_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (res_q.status == ST_FULL)) |-> ({1'b0, count_q} == (CW+1)'(CAPACITY)))
		else $error("full status with room left");

endmodule

[dv/positional_ordered_list_test.sv]
// Self-checking testbench for the positional ordered list: directed, capacity and random commands.
module positional_ordered_list_test;
	import pol_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_MAX  = 10;
	localparam int DRAIN_WAIT  = 2 * POL_CAPACITY + 8;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	logic     done;
	pol_req_t request;
	pol_res_t result;

	// Predicted list contents and the results still owed by the block
	logic signed [POL_DATA_W-1:0] list_model [POL_CAPACITY];
	int                           list_len;
	pol_res_t                     pending_results [$];

	int idle_pct;
	int mismatches;
	int results_seen;
	int commands_sent;
	int full_hits;
	int find_hits;
	int cycle_count;

	positional_ordered_list DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("positional_ordered_list verification failed");
			$finish;
		end
	end

	function automatic pol_res_t predict_list_op(pol_req_t r);
		pol_res_t res;
		int       p;
		int       i;
		logic     in_list;
		res     = '0;
		p       = int'(r.position);
		in_list = (p >= 1) && (p <= list_len);
		case (r.command)
			CMD_READ: begin
				if (in_list) res.read_value = list_model[p-1];
				else res.status = ST_INVALID;
			end
			CMD_FIND: begin
				// scan from the back so the first match wins
				res.found_position = POS_ABSENT;
				for (i = list_len - 1; i >= 0; i--)
					if (list_model[i] == r.value) res.found_position = 8'(i + 1);
			end
			CMD_INSERT: begin
				if (p < 1 || p > list_len + 1) begin
					res.status = ST_INVALID;
				end else if (list_len >= POL_CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					for (i = list_len; i > p - 1; i--) list_model[i] = list_model[i-1];
					list_model[p-1] = r.value;
					list_len++;
				end
			end
			CMD_REMOVE: begin
				if (in_list) begin
					for (i = p - 1; i + 1 < list_len; i++) list_model[i] = list_model[i+1];
					list_len--;
				end else begin
					res.status = ST_INVALID;
				end
			end
			CMD_OVERWRITE: begin
				if (in_list) list_model[p-1] = r.value;
				else res.status = ST_INVALID;
			end
			default: res.status = ST_INVALID;
		endcase
		res.list_size = 7'(list_len);
		res.is_empty  = (list_len == 0);
		return res;
	endfunction

	function automatic string bad_fields(pol_res_t w, pol_res_t g);
		string s;
		s = "";
		if (w.status !== g.status) s = {s, " status"};
		if (w.read_value !== g.read_value) s = {s, " read_value"};
		if (w.found_position !== g.found_position) s = {s, " found_position"};
		if (w.list_size !== g.list_size) s = {s, " list_size"};
		if (w.is_empty !== g.is_empty) s = {s, " is_empty"};
		return s;
	endfunction

	always @(posedge clk) begin
		pol_res_t want;
		string    diff;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("cycle %0d: result with nothing expected (st=%0d size=%0d)",
						cycle_count, result.status, result.list_size);
			end else begin
				want = pending_results.pop_front();
				results_seen++;
				diff = bad_fields(want, result);
				if (diff != "") begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display({"cycle %0d: mismatch in%s; expected st=%0d rd=%0d fp=%0d ",
							"sz=%0d empty=%0b, got st=%0d rd=%0d fp=%0d sz=%0d empty=%0b"},
							cycle_count, diff, want.status, want.read_value,
							want.found_position, want.list_size, want.is_empty,
							result.status, result.read_value, result.found_position,
							result.list_size, result.is_empty);
				end
			end
		end
	end

	// Drive one command and hold it until the block takes the transfer
	task automatic issue_command(pol_req_t r);
		pol_res_t res;
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		start   = 1'b1;
		request = r;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		res = predict_list_op(r);
		pending_results.push_back(res);
		commands_sent++;
		if (res.status == ST_FULL) full_hits++;
		if (r.command == CMD_FIND && res.found_position != POS_ABSENT) find_hits++;
	endtask

	task automatic do_cmd(logic [2:0] c, int p, logic signed [POL_DATA_W-1:0] v);
		pol_req_t r;
		r.command  = c;
		r.position = 7'(p);
		r.value    = v;
		issue_command(r);
	endtask

	function automatic logic signed [POL_DATA_W-1:0] pick_value();
		case ($urandom_range(3))
			0: return $signed($urandom_range(7)) - 4;
			1: begin
				case ($urandom_range(3))
					0: return 32'sh8000_0000;
					1: return 32'sh7FFF_FFFF;
					2: return 0;
					default: return -1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [6:0] pick_position(logic [2:0] c);
		int top;
		top = (c == CMD_INSERT) ? list_len + 1 : list_len;
		if (top == 0 || $urandom_range(99) < 12) begin
			case ($urandom_range(2))
				0: return 7'd0;
				1: return 7'(top + 1);
				default: return 7'($urandom_range(127, top + 1));
			endcase
		end
		return 7'($urandom_range(top, 1));
	endfunction

	task automatic test_empty_list();
		do_cmd(CMD_READ, 1, 0);
		do_cmd(CMD_REMOVE, 1, 0);
		do_cmd(CMD_OVERWRITE, 1, 32'sh1234_5678);
		do_cmd(CMD_FIND, 0, 0);
		do_cmd(CMD_INSERT, 0, 5);
		do_cmd(CMD_INSERT, 2, 5);
		do_cmd(CMD_READ, 0, 0);
	endtask

	task automatic test_edges_and_codes();
		do_cmd(CMD_INSERT, 1, 32'sh8000_0000);
		do_cmd(CMD_INSERT, 2, 32'sh7FFF_FFFF);
		do_cmd(CMD_INSERT, 1, 0);
		do_cmd(CMD_INSERT, 2, -1);
		do_cmd(CMD_INSERT, 6, 9);
		do_cmd(CMD_READ, 1, 0);
		do_cmd(CMD_READ, 4, 0);
		do_cmd(CMD_READ, 5, 0);
		do_cmd(CMD_READ, 127, 0);
		do_cmd(CMD_FIND, 0, 32'sh7FFF_FFFF);
		do_cmd(CMD_FIND, 127, 12345);
		do_cmd(CMD_OVERWRITE, 4, 32'sh5A5A_5A5A);
		do_cmd(CMD_OVERWRITE, 0, 1);
		do_cmd(CMD_REMOVE, 2, 0);
		do_cmd(CMD_REMOVE, 3, 0);
		do_cmd(CMD_OVERWRITE + 3'd1, 1, -1);
		do_cmd(CMD_OVERWRITE + 3'd2, 1, -1);
		do_cmd(CMD_OVERWRITE + 3'd3, 1, -1);
	endtask

	task automatic test_capacity();
		idle_pct = 14;
		while (list_len < POL_CAPACITY) do_cmd(CMD_INSERT, $urandom_range(list_len + 1, 1), pick_value());
		do_cmd(CMD_INSERT, POL_CAPACITY + 1, 1);
		do_cmd(CMD_INSERT, 1, 2);
		do_cmd(CMD_INSERT, POL_CAPACITY + 2, 3);
		do_cmd(CMD_READ, POL_CAPACITY, 0);
		do_cmd(CMD_FIND, 0, list_model[POL_CAPACITY-1]);
		do_cmd(CMD_OVERWRITE, POL_CAPACITY, 32'shA5A5_A5A5);
		do_cmd(CMD_REMOVE, POL_CAPACITY, 0);
		do_cmd(CMD_READ, POL_CAPACITY, 0);
		do_cmd(CMD_INSERT, POL_CAPACITY, -7);
		while (list_len > 0) do_cmd(CMD_REMOVE, $urandom_range(list_len, 1), pick_value());
		do_cmd(CMD_REMOVE, 1, 0);
		do_cmd(CMD_FIND, 1, 0);
	endtask

	task automatic test_random_mix(int count, int idle);
		pol_req_t r;
		int       roll;
		int       ins_end;
		int       rem_end;
		bit       grow;
		idle_pct = idle;
		grow     = 1'b1;
		repeat (count) begin
			// swing the size between empty and full so both ends get exercised
			if (list_len == 0) grow = 1'b1;
			else if (list_len == POL_CAPACITY && $urandom_range(3) == 0) grow = 1'b0;
			else if ($urandom_range(79) == 0) grow = !grow;
			ins_end = grow ? 50 : 22;
			rem_end = ins_end + (grow ? 12 : 30);
			roll    = $urandom_range(99);
			if (roll < 3) r.command = 3'($urandom_range(7, 5));
			else if (roll < ins_end) r.command = CMD_INSERT;
			else if (roll < rem_end) r.command = CMD_REMOVE;
			else if (roll < rem_end + 16) r.command = CMD_READ;
			else if (roll < rem_end + 32) r.command = CMD_FIND;
			else r.command = CMD_OVERWRITE;
			if (r.command == CMD_FIND || r.command > CMD_OVERWRITE)
				r.position = 7'($urandom_range(127));
			else
				r.position = pick_position(r.command);
			if (r.command == CMD_FIND && list_len > 0 && $urandom_range(1) == 0)
				r.value = list_model[$urandom_range(list_len - 1)];
			else
				r.value = pick_value();
			issue_command(r);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		request       = '0;
		idle_pct      = 0;
		list_len      = 0;
		mismatches    = 0;
		results_seen  = 0;
		commands_sent = 0;
		full_hits     = 0;
		find_hits     = 0;
		cycle_count   = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_list();
		test_edges_and_codes();
		test_capacity();
		test_random_mix(95, 14);
		test_random_mix(95, 60);
		test_random_mix(95, 0);

		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d commands driven, %0d results checked, %0d mismatches", commands_sent,
			results_seen, mismatches);
		$display("full-list inserts rejected: %0d, finds that hit: %0d", full_hits, find_hits);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("positional_ordered_list verification clean");
		end else begin
			$display("positional_ordered_list verification failed");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/pol_pkg.sv
rtl/pol_ram.sv
rtl/positional_ordered_list.sv
dv/positional_ordered_list_test.sv
